### hw/rtl/rti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rti_pkg: shared constants for the ray / triangle intersection pipeline
// Default widths and the configuration register map.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int CFG_ADDR_W = 3;

  // configuration register map
  localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_DIR_X    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_DIR_Y    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_DIR_Z    = 3'd5;

  localparam int NUM_RAY_REGS = 6;

endpackage

### hw/rtl/ray_triangle_intersect.sv
`timescale 1ns / 1ps
// Path: each accepted input word runs through the stage registers, the divider
//   slots and the output register to its result word.
// Throughput: one triangle per cycle when the output is empty or taken; the
//   divider chain, one stage per quotient bit, sets the depth, not the rate.
// Reset: rst_n (synchronous, active low) clears all valid bits and the ray
//   registers (origin and direction read as zero).
// ----------------------------------------------------------------------------
// ray_triangle_intersect: Cramer's rule ray / triangle test
// Exact integer determinants, sign-based barycentric test and a pipelined
// restoring divider for t, saturated to the coordinate range.
// ----------------------------------------------------------------------------
module ray_triangle_intersect #(
  parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rti_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // triangle input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [COORD_WIDTH-1:0]     in_vert_a_x,
  input  logic signed [COORD_WIDTH-1:0]     in_vert_a_y,
  input  logic signed [COORD_WIDTH-1:0]     in_vert_a_z,
  input  logic signed [COORD_WIDTH-1:0]     in_vert_b_x,
  input  logic signed [COORD_WIDTH-1:0]     in_vert_b_y,
  input  logic signed [COORD_WIDTH-1:0]     in_vert_b_z,
  input  logic signed [COORD_WIDTH-1:0]     in_vert_c_x,
  input  logic signed [COORD_WIDTH-1:0]     in_vert_c_y,
  input  logic signed [COORD_WIDTH-1:0]     in_vert_c_z,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_inside_res,
  output logic signed [COORD_WIDTH-1:0]     out_distance,
  // ray register write port
  input  logic                              cfg_we,
  input  logic [rti_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [COORD_WIDTH-1:0]            cfg_wdata
);

  // Widths: D holds a coordinate difference, PW a 2x2 product, MW a minor,
  // DW a full 3x3 determinant. Each minor is split at bit L so the dot
  // product multipliers stay near D x D.
  localparam int CW  = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int D   = CW + 1;
  localparam int PW  = 2 * D;
  localparam int MW  = PW + 1;
  localparam int L   = D;
  localparam int HW  = MW - L;
  localparam int LOW = D + L + 1;
  localparam int HIP = D + HW;
  localparam int DW  = 3 * D + 3;
  localparam int WR  = DW + CW + F;

  localparam logic [CW-1:0] MissDist = CW'(0) - (CW'(1) << F);
  localparam logic [CW-1:0] PosMax   = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] NegLim   = CW'(1) << (CW - 1);

  // cross product component indexing
  localparam int NextIdx [3] = '{1, 2, 0};
  localparam int PrevIdx [3] = '{2, 0, 1};

  // --------------------------------------------------------------------------
  // Flow control: one enable for the whole pipe. Every stage, including the
  // output register, advances when the output word is empty or taken.
  // --------------------------------------------------------------------------
  logic out_valid_r;
  logic adv;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // --------------------------------------------------------------------------
  // Ray registers
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] ray_r [rti_pkg::NUM_RAY_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rti_pkg::NUM_RAY_REGS; i++) begin
        ray_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_addr)
        rti_pkg::REG_ORIGIN_X: ray_r[0] <= cfg_wdata;
        rti_pkg::REG_ORIGIN_Y: ray_r[1] <= cfg_wdata;
        rti_pkg::REG_ORIGIN_Z: ray_r[2] <= cfg_wdata;
        rti_pkg::REG_DIR_X:    ray_r[3] <= cfg_wdata;
        rti_pkg::REG_DIR_Y:    ray_r[4] <= cfg_wdata;
        rti_pkg::REG_DIR_Z:    ray_r[5] <= cfg_wdata;
        default: ;  // drop writes beyond the map
      endcase
    end
  end

  logic signed [CW-1:0] va [3];
  logic signed [CW-1:0] vb [3];
  logic signed [CW-1:0] vc [3];

  assign va[0] = in_vert_a_x;
  assign va[1] = in_vert_a_y;
  assign va[2] = in_vert_a_z;
  assign vb[0] = in_vert_b_x;
  assign vb[1] = in_vert_b_y;
  assign vb[2] = in_vert_b_z;
  assign vc[0] = in_vert_c_x;
  assign vc[1] = in_vert_c_y;
  assign vc[2] = in_vert_c_z;

  // --------------------------------------------------------------------------
  // Stage 1: edge vectors ab = a-b, ac = a-c, ao = a-origin, plus direction
  // --------------------------------------------------------------------------
  logic                s1_v_r;
  logic signed [D-1:0] s1_ab_r  [3];
  logic signed [D-1:0] s1_ac_r  [3];
  logic signed [D-1:0] s1_ao_r  [3];
  logic signed [D-1:0] s1_dir_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s1_ab_r[k]  <= D'(va[k]) - D'(vb[k]);
        s1_ac_r[k]  <= D'(va[k]) - D'(vc[k]);
        s1_ao_r[k]  <= D'(va[k]) - D'(ray_r[k]);
        s1_dir_r[k] <= D'(ray_r[3+k]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: the six products of each cross product
  //   P = ac x dir (for A and B), Q = ab x ao (for G), R = ab x ac (for T)
  // --------------------------------------------------------------------------
  logic                 s2_v_r;
  logic signed [PW-1:0] s2_p_nxt [3][3][2];
  logic signed [PW-1:0] s2_p_r   [3][3][2];
  logic signed [D-1:0]  s2_ab_r  [3];
  logic signed [D-1:0]  s2_ao_r  [3];
  logic signed [D-1:0]  s2_dir_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s2_p_nxt[0][k][0] = PW'(s1_ac_r[NextIdx[k]]) * PW'(s1_dir_r[PrevIdx[k]]);
      s2_p_nxt[0][k][1] = PW'(s1_ac_r[PrevIdx[k]]) * PW'(s1_dir_r[NextIdx[k]]);
      s2_p_nxt[1][k][0] = PW'(s1_ab_r[NextIdx[k]]) * PW'(s1_ao_r[PrevIdx[k]]);
      s2_p_nxt[1][k][1] = PW'(s1_ab_r[PrevIdx[k]]) * PW'(s1_ao_r[NextIdx[k]]);
      s2_p_nxt[2][k][0] = PW'(s1_ab_r[NextIdx[k]]) * PW'(s1_ac_r[PrevIdx[k]]);
      s2_p_nxt[2][k][1] = PW'(s1_ab_r[PrevIdx[k]]) * PW'(s1_ac_r[NextIdx[k]]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_p_r   <= s2_p_nxt;
      s2_ab_r  <= s1_ab_r;
      s2_ao_r  <= s1_ao_r;
      s2_dir_r <= s1_dir_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: cross product components (2x2 minors)
  // --------------------------------------------------------------------------
  logic                 s3_v_r;
  logic signed [MW-1:0] s3_m_nxt [3][3];
  logic signed [MW-1:0] s3_m_r   [3][3];
  logic signed [D-1:0]  s3_ab_r  [3];
  logic signed [D-1:0]  s3_ao_r  [3];
  logic signed [D-1:0]  s3_dir_r [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 3; k++) begin
        s3_m_nxt[c][k] = MW'(s2_p_r[c][k][0]) - MW'(s2_p_r[c][k][1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_m_r   <= s3_m_nxt;
      s3_ab_r  <= s2_ab_r;
      s3_ao_r  <= s2_ao_r;
      s3_dir_r <= s2_dir_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: dot product partial products, each minor split into an
  // unsigned low half and a signed high half.
  //   A = ab.P, B = ao.P, G = dir.Q, T = ao.R
  // --------------------------------------------------------------------------
  logic                  s4_v_r;
  logic signed [D-1:0]   dot_v   [4][3];
  logic signed [MW-1:0]  dot_m   [4][3];
  logic signed [LOW-1:0] s4_lo_nxt [4][3];
  logic signed [HIP-1:0] s4_hi_nxt [4][3];
  logic signed [LOW-1:0] s4_lo_r   [4][3];
  logic signed [HIP-1:0] s4_hi_r   [4][3];

  always_comb begin
    dot_v[0] = s3_ab_r;
    dot_m[0] = s3_m_r[0];
    dot_v[1] = s3_ao_r;
    dot_m[1] = s3_m_r[0];
    dot_v[2] = s3_dir_r;
    dot_m[2] = s3_m_r[1];
    dot_v[3] = s3_ao_r;
    dot_m[3] = s3_m_r[2];
    for (int j = 0; j < 4; j++) begin
      for (int k = 0; k < 3; k++) begin
        s4_lo_nxt[j][k] = LOW'(dot_v[j][k]) *
                          LOW'($signed({1'b0, dot_m[j][k][L-1:0]}));
        s4_hi_nxt[j][k] = HIP'(dot_v[j][k]) *
                          HIP'($signed(dot_m[j][k][MW-1:L]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_lo_r <= s4_lo_nxt;
      s4_hi_r <= s4_hi_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: sum the low and high halves of each dot product separately
  // --------------------------------------------------------------------------
  logic                    s5_v_r;
  logic signed [LOW+1:0]   s5_los_r [4];
  logic signed [HIP+1:0]   s5_his_r [4];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 4; j++) begin
        s5_los_r[j] <= (LOW+2)'(s4_lo_r[j][0]) + (LOW+2)'(s4_lo_r[j][1]) +
                       (LOW+2)'(s4_lo_r[j][2]);
        s5_his_r[j] <= (HIP+2)'(s4_hi_r[j][0]) + (HIP+2)'(s4_hi_r[j][1]) +
                       (HIP+2)'(s4_hi_r[j][2]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: recombine into the four exact determinants
  // --------------------------------------------------------------------------
  logic                 s6_v_r;
  logic signed [DW-1:0] s6_det_r [4];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 4; j++) begin
        s6_det_r[j] <= (DW'(s5_his_r[j]) <<< L) + DW'(s5_los_r[j]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: flip signs so A is non-negative; take |T| and the sign of t
  // --------------------------------------------------------------------------
  logic          s7_v_r;
  logic [DW-1:0] s7_a_r;
  logic [DW-1:0] s7_b_r;
  logic [DW-1:0] s7_g_r;
  logic [DW-1:0] s7_tmag_r;
  logic          s7_tneg_r;
  logic          a_neg;

  assign a_neg = s6_det_r[0][DW-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_a_r    <= a_neg ? DW'(-s6_det_r[0]) : DW'(s6_det_r[0]);
      s7_b_r    <= a_neg ? DW'(-s6_det_r[1]) : DW'(s6_det_r[1]);
      s7_g_r    <= a_neg ? DW'(-s6_det_r[2]) : DW'(s6_det_r[2]);
      s7_tmag_r <= s6_det_r[3][DW-1] ? DW'(-s6_det_r[3]) : DW'(s6_det_r[3]);
      s7_tneg_r <= s6_det_r[3][DW-1] ^ a_neg;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8 (divider slot 0): inside test and quotient overflow check.
  // Points on an edge or a vertex count as inside.
  // --------------------------------------------------------------------------
  logic [DW:0]   bg_sum;
  logic [WR-1:0] t_num;
  logic          hit_nxt;
  logic          big_nxt;

  assign bg_sum  = (DW+1)'(s7_b_r) + (DW+1)'(s7_g_r);
  assign hit_nxt = (|s7_a_r) && !s7_b_r[DW-1] && !s7_g_r[DW-1] &&
                   (bg_sum <= (DW+1)'(s7_a_r));
  assign t_num   = WR'(s7_tmag_r) << F;
  assign big_nxt = t_num >= (WR'(s7_a_r) << CW);

  // --------------------------------------------------------------------------
  // Divider: one quotient bit per stage, most significant first.
  // Slot 0 is loaded from stage 7; slot CW holds the finished quotient.
  // --------------------------------------------------------------------------
  logic          d_v_r   [CW+1];
  logic          d_hit_r [CW+1];
  logic          d_neg_r [CW+1];
  logic          d_big_r [CW+1];
  logic [DW-1:0] d_a_r   [CW+1];
  logic [WR-1:0] d_rem_r [CW+1];
  logic [CW-1:0] d_q_r   [CW+1];

  logic [WR-1:0] d_shf     [CW];
  logic          d_ge      [CW];
  logic [WR-1:0] d_rem_nxt [CW];
  logic [CW-1:0] d_q_nxt   [CW];

  always_comb begin
    for (int i = 0; i < CW; i++) begin
      d_shf[i]     = WR'(d_a_r[i]) << (CW - 1 - i);
      d_ge[i]      = d_rem_r[i] >= d_shf[i];
      d_rem_nxt[i] = d_ge[i] ? (d_rem_r[i] - d_shf[i]) : d_rem_r[i];
      d_q_nxt[i]   = d_ge[i] ? (d_q_r[i] | (CW'(1) << (CW - 1 - i))) : d_q_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_hit_r[0] <= hit_nxt;
      d_neg_r[0] <= s7_tneg_r;
      d_big_r[0] <= big_nxt;
      d_a_r[0]   <= s7_a_r;
      d_rem_r[0] <= t_num;
      d_q_r[0]   <= '0;
      for (int i = 0; i < CW; i++) begin
        d_hit_r[i+1] <= d_hit_r[i];
        d_neg_r[i+1] <= d_neg_r[i];
        d_big_r[i+1] <= d_big_r[i];
        d_a_r[i+1]   <= d_a_r[i];
        d_rem_r[i+1] <= d_rem_nxt[i];
        d_q_r[i+1]   <= d_q_nxt[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Valid chain: advance with the data, clear on reset
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
      for (int i = 0; i <= CW; i++) begin
        d_v_r[i] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
      s7_v_r <= s6_v_r;
      d_v_r[0] <= s7_v_r;
      for (int i = 0; i < CW; i++) begin
        d_v_r[i+1] <= d_v_r[i];
      end
      out_valid_r <= d_v_r[CW];
    end
  end

  // --------------------------------------------------------------------------
  // Output register: saturate t, or give -1.0 on a miss
  // --------------------------------------------------------------------------
  logic [CW-1:0] q_fin;
  logic [CW-1:0] dist_nxt;
  logic          inside_r;
  logic [CW-1:0] dist_r;

  assign q_fin = d_q_r[CW];

  always_comb begin
    if (!d_hit_r[CW]) begin
      dist_nxt = MissDist;
    end else if (!d_neg_r[CW]) begin
      dist_nxt = (d_big_r[CW] || q_fin[CW-1]) ? PosMax : q_fin;
    end else begin
      dist_nxt = CW'(0) - ((d_big_r[CW] || (q_fin > NegLim)) ? NegLim : q_fin);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      inside_r <= d_hit_r[CW];
      dist_r   <= dist_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = inside_r;
  assign out_distance   = dist_r;

`ifndef ASSERT_OFF
  // a miss always carries -1.0
  a_miss_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_inside_res |-> out_distance == MissDist)
    else $error("miss word without -1.0 distance");

  // a held result word must block new input
  a_stall_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output stalled");

  // a stall freezes the valid chain
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable({s1_v_r, s4_v_r, s7_v_r, d_v_r[0], d_v_r[CW]}))
    else $error("pipeline moved during stall");
`endif

endmodule
